// File: rtl/core/ascs_pkg.sv
package ascs_pkg;

    // Default word memory depth; must be a power of two.
    localparam int unsigned MEM_WORDS_DEF = 16384;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ADDR_W   = 14;
    localparam int unsigned STEP_W   = 25;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [ADDR_W-1:0] STACK_START_RESET = ADDR_W'(10000);
    localparam logic [STEP_W-1:0] RUNAWAY_STEPS     = STEP_W'(1 << 24);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_EXEC    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } operation_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LIMIT  = 2'd0,
        CFG_STACK_START = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PRINT_NONE = 2'd0,
        PRINT_NUM  = 2'd1,
        PRINT_CHAR = 2'd2
    } printed_kind_t;

    typedef enum logic [2:0] {
        STOP_RUN     = 3'd0,
        STOP_HALT    = 3'd1,
        STOP_UNKNOWN = 3'd2,
        STOP_LIMIT   = 3'd3,
        STOP_RUNAWAY = 3'd4
    } stop_reason_t;

    localparam logic [7:0] OPC_LDC    = 8'd0;
    localparam logic [7:0] OPC_ADC    = 8'd1;
    localparam logic [7:0] OPC_LDL    = 8'd2;
    localparam logic [7:0] OPC_STL    = 8'd3;
    localparam logic [7:0] OPC_LDNL   = 8'd4;
    localparam logic [7:0] OPC_STNL   = 8'd5;
    localparam logic [7:0] OPC_ADD    = 8'd6;
    localparam logic [7:0] OPC_SUB    = 8'd7;
    localparam logic [7:0] OPC_SHL    = 8'd8;
    localparam logic [7:0] OPC_SHR    = 8'd9;
    localparam logic [7:0] OPC_ADJ    = 8'd10;
    localparam logic [7:0] OPC_A2SP   = 8'd11;
    localparam logic [7:0] OPC_SP2A   = 8'd12;
    localparam logic [7:0] OPC_CALL   = 8'd13;
    localparam logic [7:0] OPC_RETURN = 8'd14;
    localparam logic [7:0] OPC_BRZ    = 8'd15;
    localparam logic [7:0] OPC_BRLZ   = 8'd16;
    localparam logic [7:0] OPC_BR     = 8'd17;
    localparam logic [7:0] OPC_HALT   = 8'd18;
    localparam logic [7:0] OPC_OUT    = 8'd21;
    localparam logic [7:0] OPC_OUTC   = 8'd22;

    typedef struct packed {
        logic [1:0]               operation;
        logic [ADDR_W-1:0]        address;
        logic signed [WORD_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic [1:0]               printed_kind;
        logic signed [WORD_W-1:0] printed_value;
        logic [2:0]               stop_reason;
        logic [ADDR_W-1:0]        program_counter;
        logic signed [WORD_W-1:0] accumulator;
    } rsp_t;

endpackage

// File: rtl/core/accumulator_stack_cpu_step.sv
// Accumulator/stack CPU, stepped one request beat at a time.
//
// Request channel (req_valid / req_stall / req): each beat writes one memory
// word, restarts the machine, or fetches and executes one instruction.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
// request, in order, reporting what was printed, the stop reason, PC and A.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; index 0 is the step limit, index 1 the restart stack pointer, other
// indexes are dropped. Write config only while the block is idle.
//
// Timing: a request beat lands in a one-entry input buffer, so the next beat
// is accepted while the current one is in flight. The core takes the buffer
// when the response register is free. Memory writes, restarts and execute
// beats on a stopped machine finish in the idle state; an instruction goes
// through fetch and execute, and ldl/ldnl add a data read after execute.
// The single-port word memory sets this sequence: every access goes through
// its one port.
//
// Reset clears A, B, PC, step count and stop state, loads SP with 10000 and
// config with defaults; memory contents are undefined until written. A
// stalled response holds in its register; the core waits for it to drain
// before taking the next buffered beat, and the input buffer then stalls.
module accumulator_stack_cpu_step #(
    parameter int unsigned MEM_WORDS = ascs_pkg::MEM_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  ascs_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output ascs_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ascs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ascs_pkg::STEP_W-1:0]      cfg_data
);
    import ascs_pkg::*;

    // Word address width; MEM_WORDS must be a power of two so that the
    // signed modulo of any address is just its low bits.
    localparam int unsigned AW = $clog2(MEM_WORDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD
    } state_t;

    // Word memory, single port, registered read.
    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic              mem_en;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata_reg;

    state_t            state_reg, state_next;
    req_t              buf_reg, buf_next;
    logic              buf_valid_reg, buf_valid_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [AW-1:0]     pc_reg, pc_next;
    logic [WORD_W-1:0] sp_reg, sp_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [2:0]        stop_reg, stop_next;
    logic [STEP_W-1:0] step_limit_reg, step_limit_next;
    logic [ADDR_W-1:0] stack_start_reg, stack_start_next;

    logic              take;
    logic              finish;
    logic              req_accept;
    logic [1:0]        kind;
    logic [WORD_W-1:0] pval;

    // Decode view of the fetched word.
    logic [7:0]        opc;
    logic [WORD_W-1:0] opd;
    logic [AW-1:0]     pc_inc;
    logic [WORD_W-1:0] pc_inc_word;
    logic [AW-1:0]     pc_rel;
    logic [STEP_W-1:0] steps_inc;

    assign opc         = mem_rdata_reg[7:0];
    assign opd         = {{8{mem_rdata_reg[WORD_W-1]}}, mem_rdata_reg[WORD_W-1:8]};
    assign pc_inc      = pc_reg + AW'(1);
    assign pc_inc_word = WORD_W'(pc_inc);
    assign pc_rel      = AW'(pc_inc_word + opd);
    assign steps_inc   = steps_reg + STEP_W'(1);

    assign cfg_ready  = 1'b1;
    assign req_stall  = buf_valid_reg && !take;
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;

    // Take the buffered beat only when the response register will be free.
    assign take = (state_reg == S_IDLE) && buf_valid_reg
                  && (!out_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next       = state_reg;
        buf_next         = buf_reg;
        buf_valid_next   = buf_valid_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        pc_next          = pc_reg;
        sp_next          = sp_reg;
        steps_next       = steps_reg;
        stop_next        = stop_reg;
        step_limit_next  = step_limit_reg;
        stack_start_next = stack_start_reg;
        mem_en           = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = pc_reg;
        mem_wdata        = a_reg;
        finish           = 1'b0;
        kind             = PRINT_NONE;
        pval             = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STEP_LIMIT:  step_limit_next  = cfg_data;
                CFG_STACK_START: stack_start_next = cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end

        // Input buffer: fill on accept, drop on take.
        if (req_accept)
        begin
            buf_valid_next = 1'b1;
            buf_next       = req;
        end
        else if (take)
        begin
            buf_valid_next = 1'b0;
        end

        // Response register drains when the receiver does not stall.
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (buf_reg.operation)
                        OP_WRITE:
                        begin
                            mem_en    = 1'b1;
                            mem_we    = 1'b1;
                            mem_addr  = AW'(buf_reg.address);
                            mem_wdata = buf_reg.data;
                            finish    = 1'b1;
                        end
                        OP_EXEC:
                        begin
                            if (stop_reg != STOP_RUN)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                // Fetch the instruction at PC.
                                mem_en     = 1'b1;
                                mem_addr   = pc_reg;
                                state_next = S_DECODE;
                            end
                        end
                        OP_RESTART:
                        begin
                            a_next     = '0;
                            b_next     = '0;
                            pc_next    = '0;
                            sp_next    = WORD_W'(stack_start_reg);
                            steps_next = '0;
                            stop_next  = STOP_RUN;
                            finish     = 1'b1;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            S_DECODE:
            begin
                pc_next    = pc_inc;
                state_next = S_IDLE;
                finish     = 1'b1;
                unique case (opc)
                    OPC_LDC:
                    begin
                        b_next = a_reg;
                        a_next = opd;
                    end
                    OPC_ADC:  a_next = a_reg + opd;
                    OPC_LDL:
                    begin
                        b_next     = a_reg;
                        mem_en     = 1'b1;
                        mem_addr   = AW'(sp_reg + opd);
                        state_next = S_LOAD;
                        finish     = 1'b0;
                    end
                    OPC_STL:
                    begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = AW'(sp_reg + opd);
                        mem_wdata = a_reg;
                        a_next    = b_reg;
                    end
                    OPC_LDNL:
                    begin
                        mem_en     = 1'b1;
                        mem_addr   = AW'(a_reg + opd);
                        state_next = S_LOAD;
                        finish     = 1'b0;
                    end
                    OPC_STNL:
                    begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = AW'(a_reg + opd);
                        mem_wdata = b_reg;
                    end
                    OPC_ADD:  a_next = b_reg + a_reg;
                    OPC_SUB:  a_next = b_reg - a_reg;
                    OPC_SHL:  a_next = b_reg << a_reg[4:0];
                    OPC_SHR:  a_next = WORD_W'($signed(b_reg) >>> a_reg[4:0]);
                    OPC_ADJ:  sp_next = sp_reg + opd;
                    OPC_A2SP:
                    begin
                        sp_next = a_reg;
                        a_next  = b_reg;
                    end
                    OPC_SP2A:
                    begin
                        b_next = a_reg;
                        a_next = sp_reg;
                    end
                    OPC_CALL:
                    begin
                        b_next  = a_reg;
                        a_next  = pc_inc_word;
                        pc_next = pc_rel;
                    end
                    OPC_RETURN:
                    begin
                        pc_next = AW'(a_reg);
                        a_next  = b_reg;
                    end
                    OPC_BRZ:
                    begin
                        if (a_reg == '0)
                        begin
                            pc_next = pc_rel;
                        end
                    end
                    OPC_BRLZ:
                    begin
                        if (a_reg[WORD_W-1])
                        begin
                            pc_next = pc_rel;
                        end
                    end
                    OPC_BR:   pc_next = pc_rel;
                    OPC_HALT: ;
                    OPC_OUT:
                    begin
                        kind = PRINT_NUM;
                        pval = a_reg;
                    end
                    OPC_OUTC:
                    begin
                        kind = PRINT_CHAR;
                        pval = {24'd0, a_reg[7:0]};
                    end
                    default: ;
                endcase

                // Unknown opcodes stop without counting a step.
                if (opc == OPC_LDC || opc == OPC_ADC || opc == OPC_LDL
                    || opc == OPC_STL || opc == OPC_LDNL || opc == OPC_STNL
                    || opc == OPC_ADD || opc == OPC_SUB || opc == OPC_SHL
                    || opc == OPC_SHR || opc == OPC_ADJ || opc == OPC_A2SP
                    || opc == OPC_SP2A || opc == OPC_CALL || opc == OPC_RETURN
                    || opc == OPC_BRZ || opc == OPC_BRLZ || opc == OPC_BR
                    || opc == OPC_HALT || opc == OPC_OUT || opc == OPC_OUTC)
                begin
                    steps_next = steps_inc;
                    if (opc == OPC_HALT)
                    begin
                        stop_next = STOP_HALT;
                    end
                    else if (step_limit_reg != '0 && steps_inc >= step_limit_reg)
                    begin
                        stop_next = STOP_LIMIT;
                    end
                    else if (steps_inc > RUNAWAY_STEPS)
                    begin
                        stop_next = STOP_RUNAWAY;
                    end
                end
                else
                begin
                    stop_next = STOP_UNKNOWN;
                end
            end

            S_LOAD:
            begin
                a_next     = mem_rdata_reg;
                state_next = S_IDLE;
                finish     = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Response carries the state after the item.
        if (finish)
        begin
            out_valid_next               = 1'b1;
            out_next.printed_kind        = kind;
            out_next.printed_value       = pval;
            out_next.stop_reason         = stop_next;
            out_next.program_counter     = ADDR_W'(pc_next);
            out_next.accumulator         = a_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            buf_valid_reg   <= 1'b0;
            buf_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            a_reg           <= '0;
            b_reg           <= '0;
            pc_reg          <= '0;
            sp_reg          <= WORD_W'(STACK_START_RESET);
            steps_reg       <= '0;
            stop_reg        <= STOP_RUN;
            step_limit_reg  <= '0;
            stack_start_reg <= STACK_START_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            buf_valid_reg   <= buf_valid_next;
            buf_reg         <= buf_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            pc_reg          <= pc_next;
            sp_reg          <= sp_next;
            steps_reg       <= steps_next;
            stop_reg        <= stop_next;
            step_limit_reg  <= step_limit_next;
            stack_start_reg <= stack_start_next;
        end
    end

    // Accesses are sequenced by the state machine, so a read never overlaps
    // a write to the same word.
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
            begin
                mem[mem_addr] <= mem_wdata;
            end
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    // Nothing is in flight while a response waits in the output register.
    a_out_empty_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("response register busy while an item is in flight");

    // A data read only follows an execute cycle.
    a_load_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ($past(state_reg) == S_DECODE))
        else $error("load state entered without decode");

    // A stopped machine stays stopped until a restart is taken.
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (stop_reg != STOP_RUN && !(take && buf_reg.operation == OP_RESTART))
        |=> (stop_reg != STOP_RUN))
        else $error("stop state cleared without restart");

    // The step count never runs past the runaway stop.
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (steps_reg <= RUNAWAY_STEPS + STEP_W'(1)))
        else $error("step count past runaway bound");

    // A buffered beat is held until the core takes it.
    a_buf_held: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_valid_reg && !take) |=> (buf_valid_reg && $stable(buf_reg)))
        else $error("buffered request lost");

endmodule
